>>> hw/rtl/rwmc_pkg.sv
// rwmc_pkg: shared types, widths and codes of the random-walk maze carver
`default_nettype none

package rwmc_pkg;

    // fixed field widths
    localparam int unsigned DIM_W   = 7;   // grid size registers
    localparam int unsigned POS_W   = 7;   // internal walker row and column
    localparam int unsigned OUT_POS_W = 6; // walker row and column on the ports
    localparam int unsigned CELL_W  = 12;  // reported cell index
    localparam int unsigned COUNT_W = 13;  // unvisited count
    localparam int unsigned AREA_W  = 14;  // width times height
    localparam int unsigned PROD_W  = 16;  // row times width plus column
    localparam int unsigned EPOCH_W = 8;   // walk tag kept per cell

    localparam int unsigned DIM_VALS = 1 << DIM_W;
    localparam int unsigned DIM_MAX  = DIM_VALS - 1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    // defaults handed to the top level
    localparam int unsigned MAX_DIM_DEF   = 64;
    localparam int unsigned MAX_CELLS_DEF = 4096;
    localparam logic [DIM_W-1:0] GRID_RESET = 7'd16;

    typedef enum logic {
        OP_STEP    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    // effective grid geometry
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] cells;
    } geom_t;

endpackage

`default_nettype wire

>>> hw/rtl/rwmc_ram.sv
// rwmc_ram: generic simple dual-port ram with registered read
`default_nettype none

module rwmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/rwmc_geom.sv
// rwmc_geom: grid size registers and the clamped grid geometry
`default_nettype none

module rwmc_geom #(
    parameter int unsigned MAX_DIM   = rwmc_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_CELLS = rwmc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_index,
    input  wire logic [rwmc_pkg::DIM_W-1:0] cfg_data,
    output rwmc_pkg::geom_t                 geom,
    output logic                            busy
);

    localparam int unsigned H_LIM =
        (MAX_DIM < rwmc_pkg::DIM_MAX) ? MAX_DIM : rwmc_pkg::DIM_MAX;
    localparam int unsigned W_LIM = (H_LIM < MAX_CELLS) ? H_LIM : MAX_CELLS;

    logic [rwmc_pkg::DIM_W-1:0] width_cfg_reg;
    logic [rwmc_pkg::DIM_W-1:0] height_cfg_reg;
    logic [rwmc_pkg::DIM_W-1:0] width_eff_reg;
    logic [rwmc_pkg::DIM_W-1:0] height_eff_reg;
    logic [rwmc_pkg::AREA_W-1:0] cells_reg;
    logic                       settle_reg;
    logic [rwmc_pkg::DIM_W-1:0] width_next;
    logic [rwmc_pkg::DIM_W-1:0] height_next;
    logic [rwmc_pkg::DIM_W-1:0] quot_tab [rwmc_pkg::DIM_VALS];

    // rows that fit for each width, clipped to the register range
    for (genvar Wi = 0; Wi < rwmc_pkg::DIM_VALS; Wi++) begin : g_quot
        localparam int unsigned QRAW  = MAX_CELLS / ((Wi == 0) ? 1 : Wi);
        localparam int unsigned QCLIP =
            (QRAW > rwmc_pkg::DIM_MAX) ? rwmc_pkg::DIM_MAX : QRAW;
        assign quot_tab[Wi] = rwmc_pkg::DIM_W'(QCLIP);
    end

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= rwmc_pkg::GRID_RESET;
            height_cfg_reg <= rwmc_pkg::GRID_RESET;
        end else if (cfg_valid) begin
            unique case (rwmc_pkg::reg_idx_t'(cfg_index))
                rwmc_pkg::REG_GRID_WIDTH:  width_cfg_reg  <= cfg_data;
                rwmc_pkg::REG_GRID_HEIGHT: height_cfg_reg <= cfg_data;
            endcase
        end
    end

    // hold off items until a new size has reached the geometry registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= 1'b0;
        end else begin
            settle_reg <= cfg_valid;
        end
    end

    assign busy = cfg_valid || settle_reg;

    // clamp width, then height against its limit and the cell budget
    always_comb begin
        if (width_cfg_reg == '0) begin
            width_next = rwmc_pkg::DIM_W'(1);
        end else if (width_cfg_reg > rwmc_pkg::DIM_W'(W_LIM)) begin
            width_next = rwmc_pkg::DIM_W'(W_LIM);
        end else begin
            width_next = width_cfg_reg;
        end
        if (height_cfg_reg == '0) begin
            height_next = rwmc_pkg::DIM_W'(1);
        end else if (height_cfg_reg > rwmc_pkg::DIM_W'(H_LIM)) begin
            height_next = rwmc_pkg::DIM_W'(H_LIM);
        end else begin
            height_next = height_cfg_reg;
        end
        if (height_next > quot_tab[width_next]) begin
            height_next = quot_tab[width_next];
        end
    end

    // geometry pipeline: clamped size, then area
    always_ff @(posedge aclk) begin
        width_eff_reg  <= width_next;
        height_eff_reg <= height_next;
        cells_reg      <= rwmc_pkg::AREA_W'(width_eff_reg) *
                          rwmc_pkg::AREA_W'(height_eff_reg);
    end

    assign geom.width  = width_eff_reg;
    assign geom.height = height_eff_reg;
    assign geom.cells  = cells_reg;

endmodule

`default_nettype wire

>>> hw/rtl/random_walk_maze_carver.sv
// random_walk_maze_carver: top level of the random-walk maze carver
// Usage: each transfer on the s_ channel is one walk step (direction from an
// external random source) or a restart at a start cell. Every input item gives
// exactly one result on the m_ channel: whether a wall was carved, the cell it
// belongs to and its side, whether the walker moved, the new position and done.
// Grid width and height are written on the cfg_ channel while the block is idle
// and apply to the next item; s_ready is low during a cfg transfer and in the
// cycle after it while the clamped size settles.
// Visited cells live in a ram as a walk tag per cell; a restart only advances
// the tag. The ram read of the target cell is issued at accept; the evaluation
// state then decides, writes back and loads the output register, and no new
// item is taken before that state is left. When the 8-bit tag runs out (the 256th
// restart after reset, then every 255th) the restart first sweeps the ram.
// After reset the ram is swept with s_ready low (cfg writes are taken), the
// walker sits at row 0, column 0 and steps report done until the first
// restart. Width and height reset to 16.
// The result is held in an output register; a new item is accepted while it
// waits, and its evaluation is held while the old result waits on m_ready.
`default_nettype none

module random_walk_maze_carver #(
    parameter int unsigned MAX_DIM   = rwmc_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_CELLS = rwmc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [rwmc_pkg::DIM_W-1:0]    cfg_data,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [1:0]                    s_direction,
    input  wire logic [rwmc_pkg::OUT_POS_W-1:0] s_start_row,
    input  wire logic [rwmc_pkg::OUT_POS_W-1:0] s_start_col,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_carved,
    output logic [rwmc_pkg::CELL_W-1:0]        m_carved_cell,
    output logic [1:0]                         m_carved_wall,
    output logic                               m_moved,
    output logic [rwmc_pkg::OUT_POS_W-1:0]     m_walker_row,
    output logic [rwmc_pkg::OUT_POS_W-1:0]     m_walker_col,
    output logic                               m_done_res
);

    localparam int unsigned ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned PAD_W  = rwmc_pkg::PROD_W - rwmc_pkg::POS_W;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_CELLS - 1);

    rwmc_pkg::geom_t geom;
    logic            geom_busy;

    rwmc_pkg::state_t state_reg, state_next;
    logic [rwmc_pkg::POS_W-1:0]   cur_row_reg, cur_col_reg;
    logic [rwmc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rwmc_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [ADDR_W-1:0]            clr_reg;
    logic                         pend_reg;

    // item registers
    rwmc_pkg::opcode_t            op_reg;
    rwmc_pkg::dir_t               dir_reg;
    logic                         ok_reg;
    logic [rwmc_pkg::POS_W-1:0]   nr_reg, nc_reg;
    logic [ADDR_W-1:0]            tgt_reg;
    logic [rwmc_pkg::CELL_W-1:0]  cell_reg;

    // output register
    logic                         m_valid_reg;
    logic                         m_carved_reg;
    logic [rwmc_pkg::CELL_W-1:0]  m_cell_reg;
    logic [1:0]                   m_wall_reg;
    logic                         m_moved_reg;
    logic [rwmc_pkg::OUT_POS_W-1:0] m_row_reg, m_col_reg;
    logic                         m_done_reg;

    // accept-cycle datapath
    logic                         acc;
    logic                         is_restart;
    logic [rwmc_pkg::POS_W-1:0]   h_m1, w_m1, srow, scol, nr, nc;
    logic                         ok;
    logic [rwmc_pkg::PROD_W-1:0]  tgt_full, cell_full;

    // ram and evaluation
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
    logic [rwmc_pkg::EPOCH_W-1:0] mem_wdata, mem_rdata;
    logic                         visited;
    logic                         load_out, upd_pos, carved, moved;

    assign cfg_ready = 1'b1;

    rwmc_geom #(
        .MAX_DIM   (MAX_DIM),
        .MAX_CELLS (MAX_CELLS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .busy      (geom_busy)
    );

    rwmc_ram #(
        .WIDTH (rwmc_pkg::EPOCH_W),
        .DEPTH (MAX_CELLS)
    ) u_visited (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign acc        = s_valid && s_ready;
    assign is_restart = (rwmc_pkg::opcode_t'(s_opcode) == rwmc_pkg::OP_RESTART);

    // candidate position: saturated start cell or neighbour of the walker
    always_comb begin
        h_m1 = geom.height - 1'b1;
        w_m1 = geom.width - 1'b1;
        srow = ({1'b0, s_start_row} > h_m1) ? h_m1 : {1'b0, s_start_row};
        scol = ({1'b0, s_start_col} > w_m1) ? w_m1 : {1'b0, s_start_col};
        nr   = cur_row_reg;
        nc   = cur_col_reg;
        ok   = 1'b1;
        unique case (rwmc_pkg::dir_t'(s_direction))
            rwmc_pkg::DIR_UP: begin
                ok = (cur_row_reg != '0);
                nr = cur_row_reg - 1'b1;
            end
            rwmc_pkg::DIR_DOWN: begin
                nr = cur_row_reg + 1'b1;
            end
            rwmc_pkg::DIR_LEFT: begin
                ok = (cur_col_reg != '0);
                nc = cur_col_reg - 1'b1;
            end
            rwmc_pkg::DIR_RIGHT: begin
                nc = cur_col_reg + 1'b1;
            end
        endcase
        ok = ok && (nr < geom.height) && (nc < geom.width);
        if (is_restart) begin
            nr = srow;
            nc = scol;
        end
    end

    // linear indices of the target cell and of the cell being left
    assign tgt_full  = {{PAD_W{1'b0}}, nr} * {{PAD_W{1'b0}}, geom.width}
                     + {{PAD_W{1'b0}}, nc};
    assign cell_full = {{PAD_W{1'b0}}, cur_row_reg} * {{PAD_W{1'b0}}, geom.width}
                     + {{PAD_W{1'b0}}, cur_col_reg};

    // read the target at accept, re-read it while the result stalls
    assign mem_raddr = (state_reg == rwmc_pkg::ST_IDLE) ? tgt_full[ADDR_W-1:0] : tgt_reg;
    assign visited   = (mem_rdata == epoch_reg);

    // sequencer: sweep, wait for an item, evaluate and write back
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tgt_reg;
        mem_wdata  = epoch_reg;
        epoch_next = epoch_reg;
        count_next = count_reg;
        load_out   = 1'b0;
        upd_pos    = 1'b0;
        carved     = 1'b0;
        moved      = 1'b0;
        unique case (state_reg)
            rwmc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == CLR_LAST) begin
                    epoch_next = '0;
                    state_next = pend_reg ? rwmc_pkg::ST_EVAL : rwmc_pkg::ST_IDLE;
                end
            end
            rwmc_pkg::ST_IDLE: begin
                s_ready = !geom_busy;
                if (s_valid && !geom_busy) begin
                    if (is_restart && (epoch_reg == rwmc_pkg::EPOCH_LAST)) begin
                        state_next = rwmc_pkg::ST_CLEAR;
                    end else begin
                        state_next = rwmc_pkg::ST_EVAL;
                    end
                end
            end
            rwmc_pkg::ST_EVAL: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = rwmc_pkg::ST_IDLE;
                    if (op_reg == rwmc_pkg::OP_RESTART) begin
                        epoch_next = epoch_reg + 1'b1;
                        mem_we     = 1'b1;
                        mem_wdata  = epoch_reg + 1'b1;
                        upd_pos    = 1'b1;
                        count_next = rwmc_pkg::COUNT_W'(geom.cells - 1'b1);
                    end else if ((count_reg != '0) && ok_reg) begin
                        upd_pos = 1'b1;
                        moved   = 1'b1;
                        if (!visited) begin
                            carved     = 1'b1;
                            mem_we     = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = rwmc_pkg::ST_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rwmc_pkg::ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            epoch_reg   <= '0;
            count_reg   <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            count_reg <= count_next;
            if (state_reg == rwmc_pkg::ST_CLEAR) begin
                clr_reg <= (clr_reg == CLR_LAST) ? '0 : clr_reg + 1'b1;
            end
            if (acc && (state_next == rwmc_pkg::ST_CLEAR)) begin
                pend_reg <= 1'b1;
            end else if ((state_reg == rwmc_pkg::ST_CLEAR) && (clr_reg == CLR_LAST)) begin
                pend_reg <= 1'b0;
            end
            if (upd_pos) begin
                cur_row_reg <= nr_reg;
                cur_col_reg <= nc_reg;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture on the input transfer
    always_ff @(posedge aclk) begin
        if (acc) begin
            op_reg   <= rwmc_pkg::opcode_t'(s_opcode);
            dir_reg  <= rwmc_pkg::dir_t'(s_direction);
            ok_reg   <= ok;
            nr_reg   <= nr;
            nc_reg   <= nc;
            tgt_reg  <= tgt_full[ADDR_W-1:0];
            cell_reg <= cell_full[rwmc_pkg::CELL_W-1:0];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_carved_reg <= carved;
            m_cell_reg   <= carved ? cell_reg : '0;
            m_wall_reg   <= carved ? dir_reg : 2'd0;
            m_moved_reg  <= moved;
            m_row_reg    <= upd_pos ? nr_reg[rwmc_pkg::OUT_POS_W-1:0]
                                    : cur_row_reg[rwmc_pkg::OUT_POS_W-1:0];
            m_col_reg    <= upd_pos ? nc_reg[rwmc_pkg::OUT_POS_W-1:0]
                                    : cur_col_reg[rwmc_pkg::OUT_POS_W-1:0];
            m_done_reg   <= (count_next == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_carved      = m_carved_reg;
    assign m_carved_cell = m_cell_reg;
    assign m_carved_wall = m_wall_reg;
    assign m_moved       = m_moved_reg;
    assign m_walker_row  = m_row_reg;
    assign m_walker_col  = m_col_reg;
    assign m_done_res    = m_done_reg;

    // only a restart may raise the unvisited count
    a_count_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        !((state_reg == rwmc_pkg::ST_EVAL) && (op_reg == rwmc_pkg::OP_RESTART))
        |=> (count_reg <= $past(count_reg)))
        else $error("unvisited count rose without a restart");

    // an accepted item blocks the input for its evaluation cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item was in flight");

    // carving only happens on a move
    a_carve_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_carved) |-> m_moved)
        else $error("carved result without a move");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench of the random-walk maze carver
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rwmc_pkg::*;

    localparam int unsigned GRID_DIM      = MAX_DIM_DEF;
    localparam int unsigned GRID_CELLS    = MAX_CELLS_DEF;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_LIMIT  = 10;

    // one result of the carver, in port order
    typedef struct packed {
        logic                 carved;
        logic [CELL_W-1:0]    cell_idx;
        dir_t                 wall;
        logic                 moved;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 done;
    } step_outcome_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    reg_idx_t             cfg_index = REG_GRID_WIDTH;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    opcode_t              s_opcode    = OP_STEP;
    dir_t                 s_direction = DIR_UP;
    logic [OUT_POS_W-1:0] s_start_row = '0;
    logic [OUT_POS_W-1:0] s_start_col = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_carved;
    logic [CELL_W-1:0]    m_carved_cell;
    logic [1:0]           m_carved_wall;
    logic                 m_moved;
    logic [OUT_POS_W-1:0] m_walker_row;
    logic [OUT_POS_W-1:0] m_walker_col;
    logic                 m_done_res;

    // shadow copy of the walk state and the grid registers
    bit               cell_seen [GRID_CELLS];
    int unsigned      walk_row   = 0;
    int unsigned      walk_col   = 0;
    int unsigned      cells_left = 0;
    logic [DIM_W-1:0] grid_w_reg = GRID_RESET;
    logic [DIM_W-1:0] grid_h_reg = GRID_RESET;

    step_outcome_t step_outcome_q [$];

    bit          tx_throttle   = 1'b0;
    bit          rx_throttle   = 1'b0;
    int unsigned rx_stall_left = 0;
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned restarts_sent = 0;
    int unsigned cfg_writes    = 0;
    int unsigned results_seen  = 0;
    int unsigned carves_seen   = 0;
    int unsigned moves_seen    = 0;
    int unsigned done_seen     = 0;

    random_walk_maze_carver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_direction   (s_direction),
        .s_start_row   (s_start_row),
        .s_start_col   (s_start_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_carved      (m_carved),
        .m_carved_cell (m_carved_cell),
        .m_carved_wall (m_carved_wall),
        .m_moved       (m_moved),
        .m_walker_row  (m_walker_row),
        .m_walker_col  (m_walker_col),
        .m_done_res    (m_done_res)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // effective grid size after clamping the registers
    function automatic void eff_grid(output int unsigned w, output int unsigned h);
        w = (grid_w_reg == 0) ? 1 : ((grid_w_reg > GRID_DIM) ? GRID_DIM : grid_w_reg);
        h = (grid_h_reg == 0) ? 1 : ((grid_h_reg > GRID_DIM) ? GRID_DIM : grid_h_reg);
        if (h > GRID_CELLS / w) h = GRID_CELLS / w;
        if (h < 1) h = 1;
    endfunction

    // next result of the walk, advancing the shadow state
    function automatic step_outcome_t walk_predict(opcode_t op, dir_t dir,
                                                   logic [OUT_POS_W-1:0] srow,
                                                   logic [OUT_POS_W-1:0] scol);
        int unsigned   w, h, nr, nc;
        bit            ok;
        step_outcome_t res;
        eff_grid(w, h);
        res = '0;
        if (op == OP_RESTART) begin
            nr = (srow > h - 1) ? h - 1 : srow;
            nc = (scol > w - 1) ? w - 1 : scol;
            foreach (cell_seen[i]) cell_seen[i] = 1'b0;
            walk_row = nr;
            walk_col = nc;
            cell_seen[nr * w + nc] = 1'b1;
            cells_left = (w * h - 1) & 32'h1FFF;
        end else if (cells_left != 0) begin
            nr = walk_row;
            nc = walk_col;
            ok = 1'b1;
            case (dir)
                DIR_UP: begin
                    if (nr == 0) ok = 1'b0;
                    else nr = nr - 1;
                end
                DIR_DOWN: nr = nr + 1;
                DIR_LEFT: begin
                    if (nc == 0) ok = 1'b0;
                    else nc = nc - 1;
                end
                default: nc = nc + 1;
            endcase
            if (ok && nr < h && nc < w) begin
                // entering a fresh cell removes the wall of the cell just left
                if (!cell_seen[nr * w + nc]) begin
                    res.carved   = 1'b1;
                    res.wall     = dir;
                    res.cell_idx = CELL_W'(walk_row * w + walk_col);
                    cell_seen[nr * w + nc] = 1'b1;
                    cells_left = (cells_left - 1) & 32'h1FFF;
                end
                walk_row  = nr;
                walk_col  = nc;
                res.moved = 1'b1;
            end
        end
        res.row  = OUT_POS_W'(walk_row);
        res.col  = OUT_POS_W'(walk_col);
        res.done = (cells_left == 0);
        return res;
    endfunction

    function automatic string describe(step_outcome_t r);
        return $sformatf("carved=%0d cell=%0d wall=%0d moved=%0d row=%0d col=%0d done=%0d",
                         r.carved, r.cell_idx, r.wall, r.moved, r.row, r.col, r.done);
    endfunction

    // mostly no pause, sometimes short, now and then long
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one transfer on the input channel
    task automatic send_item(opcode_t op, dir_t dir, logic [OUT_POS_W-1:0] srow,
                             logic [OUT_POS_W-1:0] scol);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_direction <= dir;
        s_start_row <= srow;
        s_start_col <= scol;
        do @(posedge aclk); while (!s_ready);
        step_outcome_q.push_back(walk_predict(op, dir, srow, scol));
        items_sent++;
        if (op == OP_RESTART) restarts_sent++;
        gap = tx_throttle ? pause_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_step();
        send_item(OP_STEP, dir_t'($urandom_range(0, 3)), OUT_POS_W'($urandom_range(0, 63)),
                  OUT_POS_W'($urandom_range(0, 63)));
    endtask

    task automatic send_random_restart();
        send_item(OP_RESTART, dir_t'($urandom_range(0, 3)), OUT_POS_W'($urandom_range(0, 63)),
                  OUT_POS_W'($urandom_range(0, 63)));
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_WIDTH) grid_w_reg = val;
        else grid_h_reg = val;
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (step_outcome_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: compare each transfer with the oldest prediction, random stalls
    always @(posedge aclk) begin
        step_outcome_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = step_outcome_t'({m_carved, m_carved_cell, m_carved_wall, m_moved,
                                   m_walker_row, m_walker_col, m_done_res});
            results_seen++;
            if (step_outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no item outstanding: %s", $realtime,
                             describe(got));
            end else begin
                want = step_outcome_q.pop_front();
                if (got.carved !== want.carved || got.cell_idx !== want.cell_idx ||
                    got.wall !== want.wall || got.moved !== want.moved ||
                    got.row !== want.row || got.col !== want.col ||
                    got.done !== want.done) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("    expected %s", describe(want));
                        $display("    actual   %s", describe(got));
                    end
                end
                if (want.carved) carves_seen++;
                if (want.moved) moves_seen++;
                if (want.done) done_seen++;
            end
        end
        if (rx_stall_left != 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (rx_throttle && $urandom_range(0, 3) == 0) rx_stall_left = pause_len();
        end
    end

    // walk before any restart reports done, then one step each way on the reset grid
    task automatic test_power_on_walk();
        send_item(OP_STEP, DIR_DOWN, 6'h3F, 6'h3F);
        send_item(OP_STEP, DIR_RIGHT, 6'h00, 6'h00);
        send_item(OP_RESTART, DIR_UP, 6'd5, 6'd7);
        send_item(OP_STEP, DIR_UP, 6'h2A, 6'h15);
        send_item(OP_STEP, DIR_DOWN, 6'h15, 6'h2A);
        send_item(OP_STEP, DIR_LEFT, 6'h00, 6'h3F);
        send_item(OP_STEP, DIR_RIGHT, 6'h3F, 6'h00);
        drain();
    endtask

    // smallest and largest grids, clamped registers, start beyond the grid
    task automatic test_grid_extremes();
        set_grid(7'd1, 7'd1);
        send_item(OP_RESTART, DIR_UP, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_RIGHT, 6'd0, 6'd0);
        drain();
        set_grid(7'd0, 7'd0);
        send_item(OP_RESTART, DIR_DOWN, 6'd63, 6'd63);
        drain();
        set_grid(7'd127, 7'd127);
        send_item(OP_RESTART, DIR_UP, 6'd63, 6'd63);
        send_item(OP_STEP, DIR_DOWN, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_RIGHT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_UP, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_LEFT, 6'd0, 6'd0);
        drain();
        set_grid(7'd4, 7'd3);
        send_item(OP_RESTART, DIR_LEFT, 6'd63, 6'd63);
        send_item(OP_STEP, DIR_UP, 6'd0, 6'd0);
        drain();
    endtask

    // stepping back into visited cells, finishing a walk and stepping once done
    task automatic test_revisit_and_done();
        set_grid(7'd3, 7'd1);
        send_item(OP_RESTART, DIR_UP, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_RIGHT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_LEFT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_RIGHT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_RIGHT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_LEFT, 6'd0, 6'd0);
        drain();
    endtask

    // shrinking the grid under the walker: blocked, or entering the new grid
    task automatic test_resize_mid_walk();
        set_grid(7'd8, 7'd8);
        send_item(OP_RESTART, DIR_UP, 6'd7, 6'd7);
        drain();
        set_grid(7'd4, 7'd4);
        send_item(OP_STEP, DIR_LEFT, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_UP, 6'd0, 6'd0);
        drain();
        set_grid(7'd8, 7'd8);
        send_item(OP_RESTART, DIR_UP, 6'd4, 6'd3);
        drain();
        set_grid(7'd4, 7'd4);
        send_item(OP_STEP, DIR_UP, 6'd0, 6'd0);
        send_item(OP_STEP, DIR_DOWN, 6'd0, 6'd0);
        drain();
    endtask

    // enough restarts to wrap the per-cell walk tag, with a few steps after each
    task automatic test_tag_wrap();
        int unsigned n_steps;
        set_grid(7'd3, 7'd2);
        for (int i = 0; i < 270; i++) begin
            tx_throttle = (i >= 135);
            rx_throttle = (i >= 90) && (i < 220);
            send_random_restart();
            n_steps = $urandom_range(0, 2);
            repeat (n_steps) send_random_step();
        end
        drain();
    endtask

    // random walks over mostly small grids, with noise and mid-walk resizes
    task automatic test_random_walks();
        int unsigned walk_items, w, h, n_steps, squeeze_at, pick;
        walk_items = 0;
        while (walk_items < 600) begin
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                set_grid(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)));
            end else if (pick == 1) begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_GRID_WIDTH, 7'd0);
                    1: write_reg(REG_GRID_WIDTH, 7'd64);
                    2: write_reg(REG_GRID_HEIGHT, 7'd127);
                    default: write_reg(REG_GRID_HEIGHT, 7'd1);
                endcase
            end else if (pick == 2) begin
                write_reg(reg_idx_t'($urandom_range(0, 1)), DIM_W'($urandom_range(1, 6)));
            end else begin
                set_grid(DIM_W'($urandom_range(1, 5)), DIM_W'($urandom_range(1, 5)));
            end
            eff_grid(w, h);
            n_steps = ((w * h * 6 > 60) ? 60 : w * h * 6) + $urandom_range(0, 4);
            squeeze_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_steps) : 0;
            // usually a fresh walk, sometimes carry on after a resize
            if ($urandom_range(0, 99) < 85) begin
                send_random_restart();
                walk_items++;
            end
            for (int i = 1; i <= n_steps; i++) begin
                if (i == squeeze_at) drain();
                if ($urandom_range(0, 99) < 6) send_random_restart();
                else send_random_step();
                walk_items++;
            end
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_on_walk();
        test_grid_extremes();
        test_revisit_and_done();
        test_resize_mid_walk();
        test_tag_wrap();
        test_random_walks();
        drain();
        $display("covered %0d items, %0d restarts, %0d grid register writes",
                 items_sent, restarts_sent, cfg_writes);
        $display("%0d results: %0d carves, %0d moves, %0d done, %0d mismatches",
                 results_seen, carves_seen, moves_seen, done_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", step_outcome_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rwmc_pkg.sv
hw/rtl/rwmc_ram.sv
hw/rtl/rwmc_geom.sv
hw/rtl/random_walk_maze_carver.sv
dv/tb_top.sv
